// File: design/servo_angle_to_pulse_ramp_top_assert.svh
// Assertion macros shared by the checker of the servo pulse block.
// Both sample on clk and are disabled while arst_n is low.
`ifndef SERVO_ANGLE_TO_PULSE_RAMP_TOP_ASSERT_SVH
`define SERVO_ANGLE_TO_PULSE_RAMP_TOP_ASSERT_SVH

// The consequent must hold in the cycle after the antecedent.
`define SAPR_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

// The consequent must hold in the same cycle as the antecedent.
`define SAPR_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

// File: design/sapr_pkg.sv
`default_nettype none

package sapr_pkg;

	// Command codes.
	localparam logic [2:0] ACT_ABS   = 3'd0;
	localparam logic [2:0] ACT_REL   = 3'd1;
	localparam logic [2:0] ACT_MOVE  = 3'd2;
	localparam logic [2:0] ACT_TICK  = 3'd3;
	localparam logic [2:0] ACT_PULSE = 3'd4;

	// Configuration register indexes.
	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] CFG_MIN_ANGLE = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_ANGLE = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MIN_PULSE = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_PULSE = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_PERIOD    = 3'd4;
	localparam int CFG_DATA_W = 16;

	// Reset values.
	localparam logic signed [15:0] RST_MIN_ANGLE = 16'sd0;
	localparam logic signed [15:0] RST_MAX_ANGLE = 16'sd18000;
	localparam logic [15:0] RST_MIN_PULSE = 16'd500;
	localparam logic [15:0] RST_MAX_PULSE = 16'd2500;
	localparam logic [15:0] RST_PERIOD    = 16'd19999;

	// Shared divider geometry.
	localparam int DIV_NUM_W         = 50;
	localparam int DIV_DEN_W         = 17;
	localparam int DIV_SHORT_W       = 34;
	localparam int DIV_BITS_PER_STEP = 2;
	localparam int DIV_LONG_STEPS    = DIV_NUM_W / DIV_BITS_PER_STEP;
	localparam int DIV_SHORT_STEPS   = DIV_SHORT_W / DIV_BITS_PER_STEP;
	localparam int DIV_CNT_W         = $clog2(DIV_LONG_STEPS + 1);

	typedef struct packed {
		logic [2:0]         action;
		logic               forward;
		logic signed [15:0] angle_value;
		logic [15:0]        move_time;
		logic [15:0]        pulse_value;
	} in_item_t;

	typedef struct packed {
		logic [15:0]        pulse_width;
		logic signed [15:0] current_angle;
		logic               move_done;
	} out_item_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_ABS,
		ST_REL,
		ST_MSET,
		ST_MCHK,
		ST_MMUL,
		ST_MDIV_GO,
		ST_MDIV_WAIT,
		ST_MSUB,
		ST_TGT,
		ST_CLAMP,
		ST_MAP_MUL,
		ST_MAP_GO,
		ST_MAP_WAIT,
		ST_MAP_END,
		ST_FLAT,
		ST_PV,
		ST_DRIVE,
		ST_TICK,
		ST_EMIT
	} state_t;

	typedef enum logic [4:0] {
		OP_NONE,
		OP_LOAD,
		OP_ABS,
		OP_REL,
		OP_MSET,
		OP_MMUL,
		OP_MSUB,
		OP_TGT,
		OP_CLAMP,
		OP_MAP_MUL,
		OP_MAP_GO,
		OP_MAP_END,
		OP_FLAT,
		OP_PV,
		OP_DRIVE,
		OP_TICK,
		OP_EMIT
	} dp_op_t;

	typedef struct packed {
		dp_op_t op;
		logic   div_start;
		logic   div_long;
	} cmd_t;

	typedef struct packed {
		logic move_fin;
		logic range_pos;
		logic div_busy;
		logic out_free;
	} sts_t;

endpackage

`default_nettype wire

// File: design/sapr_div.sv
`default_nettype none

// Restoring unsigned divider, two quotient bits per cycle.
// The short mode takes a narrower dividend and needs fewer steps.
module sapr_div (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic                           long_mode,
	input  logic [sapr_pkg::DIV_NUM_W-1:0] num,
	input  logic [sapr_pkg::DIV_DEN_W-1:0] den,
	output logic                           busy,
	output logic [sapr_pkg::DIV_NUM_W-1:0] quo
);

	localparam int NumW = sapr_pkg::DIV_NUM_W;
	localparam int DenW = sapr_pkg::DIV_DEN_W;
	localparam int ShortW = sapr_pkg::DIV_SHORT_W;
	localparam int CntW = sapr_pkg::DIV_CNT_W;

	logic [CntW-1:0] cnt_q;
	logic [NumW-1:0] nq_q, nq_d;
	logic [DenW-1:0] rem_q, rem_d, den_q;
	logic [DenW:0]   trial;

	always_comb begin
		nq_d = nq_q;
		rem_d = rem_q;
		trial = '0;
		for (int i = 0; i < sapr_pkg::DIV_BITS_PER_STEP; i++) begin
			trial = {rem_d, nq_d[NumW-1]};
			nq_d = {nq_d[NumW-2:0], 1'b0};
			if (trial >= {1'b0, den_q}) begin
				rem_d = DenW'(trial - {1'b0, den_q});
				nq_d[0] = 1'b1;
			end else begin
				rem_d = trial[DenW-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= long_mode ? CntW'(sapr_pkg::DIV_LONG_STEPS)
				: CntW'(sapr_pkg::DIV_SHORT_STEPS);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - CntW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			nq_q <= long_mode ? num : {num[ShortW-1:0], {(NumW - ShortW){1'b0}}};
			rem_q <= '0;
			den_q <= den;
		end else if (cnt_q != '0) begin
			nq_q <= nq_d;
			rem_q <= rem_d;
		end
	end

	assign busy = (cnt_q != '0);
	assign quo = nq_q;

endmodule

`default_nettype wire

// File: design/sapr_ctrl.sv
`default_nettype none

// Sequencer: walks one command through the datapath steps.
module sapr_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  logic [2:0]            in_action,
	output logic                  in_stall,
	input  sapr_pkg::sts_t        sts,
	output sapr_pkg::cmd_t        cmd
);

	sapr_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sapr_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			sapr_pkg::ST_IDLE: begin
				if (in_valid) begin
					case (in_action)
						sapr_pkg::ACT_ABS:   state_d = sapr_pkg::ST_ABS;
						sapr_pkg::ACT_REL:   state_d = sapr_pkg::ST_REL;
						sapr_pkg::ACT_MOVE:  state_d = sapr_pkg::ST_MSET;
						sapr_pkg::ACT_TICK:  state_d = sapr_pkg::ST_TICK;
						sapr_pkg::ACT_PULSE: state_d = sapr_pkg::ST_PV;
						default:             state_d = sapr_pkg::ST_EMIT;
					endcase
				end
			end
			sapr_pkg::ST_ABS:     state_d = sapr_pkg::ST_CLAMP;
			sapr_pkg::ST_REL:     state_d = sapr_pkg::ST_CLAMP;
			sapr_pkg::ST_MSET:    state_d = sapr_pkg::ST_MCHK;
			sapr_pkg::ST_MCHK: begin
				state_d = sts.move_fin ? sapr_pkg::ST_TGT : sapr_pkg::ST_MMUL;
			end
			sapr_pkg::ST_MMUL:    state_d = sapr_pkg::ST_MDIV_GO;
			sapr_pkg::ST_MDIV_GO: state_d = sapr_pkg::ST_MDIV_WAIT;
			sapr_pkg::ST_MDIV_WAIT: begin
				if (!sts.div_busy) begin
					state_d = sapr_pkg::ST_MSUB;
				end
			end
			sapr_pkg::ST_MSUB:    state_d = sapr_pkg::ST_CLAMP;
			sapr_pkg::ST_TGT:     state_d = sapr_pkg::ST_CLAMP;
			sapr_pkg::ST_CLAMP: begin
				state_d = sts.range_pos ? sapr_pkg::ST_MAP_MUL : sapr_pkg::ST_FLAT;
			end
			sapr_pkg::ST_MAP_MUL: state_d = sapr_pkg::ST_MAP_GO;
			sapr_pkg::ST_MAP_GO:  state_d = sapr_pkg::ST_MAP_WAIT;
			sapr_pkg::ST_MAP_WAIT: begin
				if (!sts.div_busy) begin
					state_d = sapr_pkg::ST_MAP_END;
				end
			end
			sapr_pkg::ST_MAP_END: state_d = sapr_pkg::ST_DRIVE;
			sapr_pkg::ST_FLAT:    state_d = sapr_pkg::ST_DRIVE;
			sapr_pkg::ST_PV:      state_d = sapr_pkg::ST_DRIVE;
			sapr_pkg::ST_DRIVE:   state_d = sapr_pkg::ST_EMIT;
			sapr_pkg::ST_TICK:    state_d = sapr_pkg::ST_EMIT;
			sapr_pkg::ST_EMIT: begin
				if (sts.out_free) begin
					state_d = sapr_pkg::ST_IDLE;
				end
			end
			default:              state_d = sapr_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd.op = sapr_pkg::OP_NONE;
		cmd.div_start = 1'b0;
		cmd.div_long = 1'b0;
		case (state_q)
			sapr_pkg::ST_IDLE: begin
				if (in_valid) begin
					cmd.op = sapr_pkg::OP_LOAD;
				end
			end
			sapr_pkg::ST_ABS:     cmd.op = sapr_pkg::OP_ABS;
			sapr_pkg::ST_REL:     cmd.op = sapr_pkg::OP_REL;
			sapr_pkg::ST_MSET:    cmd.op = sapr_pkg::OP_MSET;
			sapr_pkg::ST_MMUL:    cmd.op = sapr_pkg::OP_MMUL;
			sapr_pkg::ST_MDIV_GO: begin
				cmd.div_start = 1'b1;
				cmd.div_long = 1'b1;
			end
			sapr_pkg::ST_MSUB:    cmd.op = sapr_pkg::OP_MSUB;
			sapr_pkg::ST_TGT:     cmd.op = sapr_pkg::OP_TGT;
			sapr_pkg::ST_CLAMP:   cmd.op = sapr_pkg::OP_CLAMP;
			sapr_pkg::ST_MAP_MUL: cmd.op = sapr_pkg::OP_MAP_MUL;
			sapr_pkg::ST_MAP_GO: begin
				cmd.op = sapr_pkg::OP_MAP_GO;
				cmd.div_start = 1'b1;
			end
			sapr_pkg::ST_MAP_END: cmd.op = sapr_pkg::OP_MAP_END;
			sapr_pkg::ST_FLAT:    cmd.op = sapr_pkg::OP_FLAT;
			sapr_pkg::ST_PV:      cmd.op = sapr_pkg::OP_PV;
			sapr_pkg::ST_DRIVE:   cmd.op = sapr_pkg::OP_DRIVE;
			sapr_pkg::ST_TICK:    cmd.op = sapr_pkg::OP_TICK;
			sapr_pkg::ST_EMIT: begin
				if (sts.out_free) begin
					cmd.op = sapr_pkg::OP_EMIT;
				end
			end
			default:              cmd.op = sapr_pkg::OP_NONE;
		endcase
	end

	assign in_stall = (state_q != sapr_pkg::ST_IDLE);

endmodule

`default_nettype wire

// File: design/sapr_dp.sv
`default_nettype none

// Datapath: configuration, servo state, working registers, output register.
module sapr_dp (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [sapr_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [sapr_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  sapr_pkg::in_item_t                 in_data,
	input  sapr_pkg::cmd_t                     cmd,
	output sapr_pkg::sts_t                     sts,
	output logic                               out_valid,
	input  logic                               out_stall,
	output sapr_pkg::out_item_t                out_data
);

	localparam int NumW = sapr_pkg::DIV_NUM_W;
	localparam int DenW = sapr_pkg::DIV_DEN_W;
	localparam int ShortW = sapr_pkg::DIV_SHORT_W;

	function automatic logic signed [15:0] clamp_angle(input logic signed [NumW-1:0] a,
		input logic signed [15:0] lo, input logic signed [15:0] hi);
		logic signed [NumW-1:0] lo_w;
		logic signed [NumW-1:0] hi_w;
		logic signed [NumW-1:0] r;
		lo_w = NumW'(lo);
		hi_w = NumW'(hi);
		if (a < lo_w) begin
			r = lo_w;
		end else if (hi_w < a) begin
			r = hi_w;
		end else begin
			r = a;
		end
		return r[15:0];
	endfunction

	// Configuration registers.
	logic signed [15:0] min_angle_q, max_angle_q;
	logic [15:0]        min_pulse_q, max_pulse_q, period_q;

	// Servo state.
	logic signed [15:0] angle_now_q, target_q;
	logic [15:0]        pulse_now_q, dur_q;
	logic [31:0]        end_tick_q, tick_q;
	logic signed [16:0] span_q;

	// Working registers.
	sapr_pkg::in_item_t     cmd_q;
	logic signed [NumW-1:0] ang_q;
	logic signed [NumW-1:0] prod_q;
	logic                   neg_q;
	logic                   done_q;
	logic [15:0]            pmap_q;
	sapr_pkg::out_item_t    out_q;
	logic                   out_valid_q;

	logic signed [16:0]     av_dir;
	logic signed [17:0]     rel_sum;
	logic signed [15:0]     tgt_w;
	logic                   move_new;
	logic [31:0]            rem_ticks;
	logic signed [32:0]     rem_s;
	logic signed [NumW-1:0] move_prod;
	logic signed [16:0]     range_w;
	logic signed [16:0]     ang_off;
	logic signed [16:0]     pulse_span;
	logic signed [33:0]     map_prod;
	logic signed [35:0]     map_num;
	logic [35:0]            map_mag;
	logic [NumW-1:0]        abs_prod;
	logic [NumW-1:0]        div_num;
	logic [DenW-1:0]        div_den;
	logic                   div_busy;
	logic [NumW-1:0]        quo;
	logic signed [NumW-1:0] quo_signed;
	logic signed [17:0]     map_q;
	logic signed [18:0]     mapped;
	logic [15:0]            mapped_sat;
	logic [15:0]            lim_hi, lim_lo, pulse_lim;
	logic                   out_free;

	assign av_dir = cmd_q.forward ? 17'(cmd_q.angle_value) : -17'(cmd_q.angle_value);
	assign rel_sum = 18'(angle_now_q) + 18'(av_dir);

	assign tgt_w = clamp_angle(NumW'(cmd_q.angle_value), min_angle_q, max_angle_q);
	assign move_new = (tgt_w != target_q) || (cmd_q.move_time != dur_q);

	// Ticks left until the move ends, times the stored span.
	assign rem_ticks = end_tick_q - tick_q;
	assign rem_s = signed'({1'b0, rem_ticks});
	assign move_prod = rem_s * span_q;

	assign range_w = 17'(max_angle_q) - 17'(min_angle_q);
	assign ang_off = 17'(angle_now_q) - 17'(min_angle_q);
	assign pulse_span = signed'({1'b0, max_pulse_q}) - signed'({1'b0, min_pulse_q});
	assign map_prod = ang_off * pulse_span;

	// Half-up rounding as floor((2n + D) / 2D); a negative dividend is
	// complemented before the unsigned divide and the quotient after it.
	assign map_num = (36'(prod_q) <<< 1) + 36'(range_w);
	assign map_mag = map_num[35] ? ~map_num : map_num;
	assign abs_prod = prod_q[NumW-1] ? NumW'(-prod_q) : NumW'(prod_q);

	assign div_num = cmd.div_long ? abs_prod : {{(NumW - ShortW){1'b0}}, map_mag[ShortW-1:0]};
	assign div_den = cmd.div_long ? DenW'(dur_q) : {range_w[15:0], 1'b0};

	sapr_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (cmd.div_start),
		.long_mode (cmd.div_long),
		.num       (div_num),
		.den       (div_den),
		.busy      (div_busy),
		.quo       (quo)
	);

	assign quo_signed = neg_q ? -signed'(quo) : signed'(quo);

	assign map_q = neg_q ? ~signed'({1'b0, quo[16:0]}) : signed'({1'b0, quo[16:0]});
	assign mapped = signed'({3'b000, min_pulse_q}) + 19'(map_q);
	always_comb begin
		if (mapped < 19'sd0) begin
			mapped_sat = 16'd0;
		end else if (mapped > 19'sd65535) begin
			mapped_sat = 16'hFFFF;
		end else begin
			mapped_sat = mapped[15:0];
		end
	end

	assign lim_hi = (max_pulse_q < period_q) ? max_pulse_q : period_q;
	assign lim_lo = (min_pulse_q < lim_hi) ? min_pulse_q : lim_hi;
	always_comb begin
		if (pmap_q < lim_lo) begin
			pulse_lim = lim_lo;
		end else if (lim_hi < pmap_q) begin
			pulse_lim = lim_hi;
		end else begin
			pulse_lim = pmap_q;
		end
	end

	assign out_free = !out_valid_q || !out_stall;

	assign sts.move_fin = (dur_q == 16'd0) || (end_tick_q <= tick_q);
	assign sts.range_pos = !range_w[16] && (range_w != 17'sd0);
	assign sts.div_busy = div_busy;
	assign sts.out_free = out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_angle_q <= sapr_pkg::RST_MIN_ANGLE;
			max_angle_q <= sapr_pkg::RST_MAX_ANGLE;
			min_pulse_q <= sapr_pkg::RST_MIN_PULSE;
			max_pulse_q <= sapr_pkg::RST_MAX_PULSE;
			period_q <= sapr_pkg::RST_PERIOD;
		end else if (cfg_we) begin
			case (cfg_index)
				sapr_pkg::CFG_MIN_ANGLE: min_angle_q <= signed'(cfg_data);
				sapr_pkg::CFG_MAX_ANGLE: max_angle_q <= signed'(cfg_data);
				sapr_pkg::CFG_MIN_PULSE: min_pulse_q <= cfg_data;
				sapr_pkg::CFG_MAX_PULSE: max_pulse_q <= cfg_data;
				sapr_pkg::CFG_PERIOD:    period_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			angle_now_q <= '0;
			pulse_now_q <= sapr_pkg::RST_MIN_PULSE;
			target_q <= '0;
			dur_q <= '0;
			end_tick_q <= '0;
			span_q <= '0;
			tick_q <= '0;
		end else begin
			case (cmd.op)
				sapr_pkg::OP_MSET: begin
					if (move_new) begin
						target_q <= tgt_w;
						dur_q <= cmd_q.move_time;
						end_tick_q <= tick_q + 32'(cmd_q.move_time);
						span_q <= 17'(tgt_w) - 17'(angle_now_q);
					end
				end
				sapr_pkg::OP_CLAMP: angle_now_q <= clamp_angle(ang_q, min_angle_q, max_angle_q);
				sapr_pkg::OP_DRIVE: pulse_now_q <= pulse_lim;
				sapr_pkg::OP_TICK:  tick_q <= tick_q + 32'd1;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			sapr_pkg::OP_LOAD: begin
				cmd_q <= in_data;
				done_q <= 1'b0;
			end
			sapr_pkg::OP_ABS:     ang_q <= NumW'(av_dir);
			sapr_pkg::OP_REL:     ang_q <= NumW'(rel_sum);
			sapr_pkg::OP_MMUL: begin
				prod_q <= move_prod;
				neg_q <= move_prod[NumW-1];
			end
			sapr_pkg::OP_MSUB:    ang_q <= NumW'(target_q) - quo_signed;
			sapr_pkg::OP_TGT: begin
				ang_q <= NumW'(target_q);
				done_q <= 1'b1;
			end
			sapr_pkg::OP_MAP_MUL: prod_q <= NumW'(map_prod);
			sapr_pkg::OP_MAP_GO:  neg_q <= map_num[35];
			sapr_pkg::OP_MAP_END: pmap_q <= mapped_sat;
			sapr_pkg::OP_FLAT:    pmap_q <= min_pulse_q;
			sapr_pkg::OP_PV:      pmap_q <= cmd_q.pulse_value;
			sapr_pkg::OP_EMIT: begin
				out_q.pulse_width <= pulse_now_q;
				out_q.current_angle <= angle_now_q;
				out_q.move_done <= done_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.op == sapr_pkg::OP_EMIT) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data = out_q;

endmodule

`default_nettype wire

// File: design/servo_angle_to_pulse_ramp_top.sv
// Servo angle to PWM compare value mapper with timed moves.
// Requests enter on in_valid/in_stall with an in_item_t payload; one result
// leaves per request on out_valid/out_stall with an out_item_t payload. A
// request is taken at a clock edge where in_valid is high and in_stall low.
// Configuration is a write port: cfg_we, cfg_index (0 min angle, 1 max angle,
// 2 min pulse, 3 max pulse, 4 counter period) and cfg_data; writes to other
// indexes are dropped. Write it only while no request is in flight.
// One request is worked at a time; the next is taken only once the result
// has gone into the output register. Unused codes go straight to the output
// step, a tick advances the tick count, a direct pulse is limited,
// and an angle is clamped and mapped onto the pulse range by the shared
// divider, which yields two quotient bits per cycle; an empty angle range
// skips the divide. A timed move still under way first interpolates its
// angle with the divider in its long mode; the mapping uses the short mode.
// Reset clears the servo state to angle 0, pulse 500, tick count 0, and loads
// the configuration defaults. When the receiver stalls, the finished result
// waits in the output register and a new request is still taken; it is then
// held in its last step until the output register frees up.
`default_nettype none

module servo_angle_to_pulse_ramp_top (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  sapr_pkg::in_item_t              in_data,
	output logic                            out_valid,
	input  logic                            out_stall,
	output sapr_pkg::out_item_t             out_data,
	input  logic                            cfg_we,
	input  logic [sapr_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [sapr_pkg::CFG_DATA_W-1:0] cfg_data
);

	// Command and status between the sequencer and the datapath.
	sapr_pkg::cmd_t cmd;
	sapr_pkg::sts_t sts;

	// The sequencer steps through one request and holds in_stall high
	// until the result has been placed in the output register.
	sapr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_action (in_data.action),
		.in_stall  (in_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	// The datapath keeps the configuration, the servo state, the shared
	// divider and the output register.
	sapr_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_data   (in_data),
		.cmd       (cmd),
		.sts       (sts),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

endmodule

`default_nettype wire

// File: design/sapr_checker.sv
`default_nettype none

`include "servo_angle_to_pulse_ramp_top_assert.svh"

// Port-level checks for the servo pulse block.
module sapr_checker (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	input  logic                            in_stall,
	input  logic                            out_valid,
	input  logic                            out_stall,
	input  sapr_pkg::out_item_t             out_data
);

	// A taken request raises in_stall in the cycle after it.
	`SAPR_ASSERT_NEXT(a_busy_after_req, in_valid && !in_stall, in_stall, "request not held busy")

	// A result only appears from a step of a request in flight.
	`SAPR_ASSERT_NOW(a_result_from_work, $rose(out_valid), $past(in_stall), "result without request")

	// A stalled result stays and does not change.
	`SAPR_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data),
		"stalled result changed")

endmodule

bind servo_angle_to_pulse_ramp_top sapr_checker u_sapr_checker (.*);

`default_nettype wire

// File: dv/tb_servo_angle_to_pulse_ramp_top.sv
`timescale 1ns / 100ps

module tb_servo_angle_to_pulse_ramp_top;

	// The block has no names for the spare command codes. They must change
	// nothing, so they get names of their own here.
	localparam logic [2:0] ACT_SPARE5 = 3'd5;
	localparam logic [2:0] ACT_SPARE6 = 3'd6;
	localparam logic [2:0] ACT_SPARE7 = 3'd7;

	// The slowest request is a timed move still under way. Even with the
	// longest receiver stall and sender gap on every request, a correct run
	// stays far below this limit.
	localparam int CYCLE_LIMIT   = 1_000_000;
	localparam int DRAIN_CYCLES  = 60;
	localparam int SETTLE_CYCLES = 4;
	localparam int REPORT_LIMIT  = 10;

	logic                            clk       = 1'b0;
	logic                            arst_n    = 1'b0;
	logic                            in_valid  = 1'b0;
	logic                            in_stall;
	sapr_pkg::in_item_t              in_data   = '0;
	logic                            out_valid;
	logic                            out_stall = 1'b0;
	sapr_pkg::out_item_t             out_data;
	logic                            cfg_we    = 1'b0;
	logic [sapr_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
	logic [sapr_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

	servo_angle_to_pulse_ramp_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #6 clk = ~clk;

	// Our copy of the range registers, updated at the edge that writes them.
	bit signed [15:0] lim_min_angle;
	bit signed [15:0] lim_max_angle;
	bit [15:0]        lim_min_pulse;
	bit [15:0]        lim_max_pulse;
	bit [15:0]        lim_period;

	// Our copy of the servo state, kept at the widths the block uses.
	bit signed [15:0] angle_held;
	bit [15:0]        pulse_held;
	bit signed [15:0] target_held;
	bit [15:0]        move_ms;
	bit [31:0]        end_tick;
	bit signed [16:0] span_held;
	bit [31:0]        tick_count;

	// Results that accepted requests still owe, oldest first.
	sapr_pkg::out_item_t pending_outputs[$];

	int  fail_count     = 0;
	int  items_sent     = 0;
	int  results_seen   = 0;
	int  moves_landed   = 0;
	int  range_settings = 1;
	int  cycle_count    = 0;
	int  burst_left     = 0;
	int  stall_run      = 0;
	bit  stall_hold     = 1'b0;
	bit  last_done      = 1'b0;
	sapr_pkg::out_item_t want;

	// Clamp an angle to the configured range. The low bound is tested first,
	// so an empty range settles on its one value and an inverted one on either end.
	function automatic longint clamp_deg(longint a);
		if (a < longint'(lim_min_angle))
			return longint'(lim_min_angle);
		if (longint'(lim_max_angle) < a)
			return longint'(lim_max_angle);
		return a;
	endfunction

	// Hold a pulse inside the pulse range and no higher than the counter
	// period. The period wins over both ends of the range.
	function automatic void limit_pulse(longint p);
		longint hi;
		longint lo;
		hi = (lim_max_pulse < lim_period) ? longint'(lim_max_pulse) : longint'(lim_period);
		lo = (longint'(lim_min_pulse) < hi) ? longint'(lim_min_pulse) : hi;
		if (p < lo)
			p = lo;
		else if (hi < p)
			p = hi;
		pulse_held = p[15:0];
	endfunction

	// Clamp an angle, keep it, and map it linearly onto the pulse range with
	// rounding half up. An inverted pulse range just gives a negative slope.
	function automatic void steer_to(longint a);
		longint c;
		longint d;
		longint num;
		longint den;
		longint q;
		longint mapped;
		c = clamp_deg(a);
		angle_held = c[15:0];
		d = longint'(lim_max_angle) - longint'(lim_min_angle);
		if (d > 0) begin
			num = 2 * (c - longint'(lim_min_angle))
				* (longint'(lim_max_pulse) - longint'(lim_min_pulse)) + d;
			den = 2 * d;
			q = num / den;
			if (num % den != 0 && num < 0)
				q--;
			mapped = longint'(lim_min_pulse) + q;
		end else begin
			mapped = longint'(lim_min_pulse);
		end
		if (mapped < 0)
			mapped = 0;
		else if (mapped > 65535)
			mapped = 65535;
		limit_pulse(mapped);
	endfunction

	// Apply one request to our copy of the servo and return what the block
	// must answer.
	function automatic sapr_pkg::out_item_t advance_servo(sapr_pkg::in_item_t cmd);
		sapr_pkg::out_item_t res;
		longint    step;
		longint    tgt;
		longint    diff;
		longint    rem;
		longint    q;
		logic      done;
		done = 1'b0;
		step = cmd.forward ? longint'(cmd.angle_value) : -longint'(cmd.angle_value);
		case (cmd.action)
			sapr_pkg::ACT_ABS: steer_to(step);
			sapr_pkg::ACT_REL: steer_to(longint'(angle_held) + step);
			sapr_pkg::ACT_MOVE: begin
				// A new target or duration restarts the move from the
				// angle held right now; a repeat just advances it.
				tgt = clamp_deg(longint'(cmd.angle_value));
				if (tgt[15:0] != target_held || cmd.move_time != move_ms) begin
					target_held = tgt[15:0];
					move_ms = cmd.move_time;
					end_tick = tick_count + 32'(cmd.move_time);
					diff = tgt - longint'(angle_held);
					span_held = diff[16:0];
				end
				if (move_ms == 0 || end_tick <= tick_count) begin
					steer_to(longint'(target_held));
					done = 1'b1;
				end else begin
					// The quotient truncates toward zero.
					rem = longint'(end_tick - tick_count);
					q = (rem * longint'(span_held)) / longint'(move_ms);
					steer_to(longint'(target_held) - q);
				end
			end
			sapr_pkg::ACT_TICK: tick_count++;
			sapr_pkg::ACT_PULSE: limit_pulse(longint'(cmd.pulse_value));
			default: ;
		endcase
		res.pulse_width = pulse_held;
		res.current_angle = angle_held;
		res.move_done = done;
		return res;
	endfunction

	function automatic sapr_pkg::in_item_t make_cmd(input logic [2:0] action, input logic fwd,
		input int angle, input int mtime, input int pval);
		sapr_pkg::in_item_t c;
		c.action = action;
		c.forward = fwd;
		c.angle_value = angle[15:0];
		c.move_time = mtime[15:0];
		c.pulse_value = pval[15:0];
		return c;
	endfunction

	// Any code, any field values: most angles land outside the range.
	function automatic sapr_pkg::in_item_t stray_cmd();
		return make_cmd(3'($urandom_range(sapr_pkg::ACT_ABS, ACT_SPARE7)),
			1'($urandom_range(0, 1)), $urandom, $urandom, $urandom);
	endfunction

	// Angles near the configured span so that the mapping sees mid values,
	// small relative steps, and direct pulses.
	function automatic sapr_pkg::in_item_t sweep_cmd();
		case ($urandom_range(0, 2))
			0: return make_cmd(sapr_pkg::ACT_ABS, 1'($urandom_range(0, 1)),
				int'($urandom_range(0, 36999)) - 18500, $urandom, $urandom);
			1: return make_cmd(sapr_pkg::ACT_REL, 1'($urandom_range(0, 1)),
				int'($urandom_range(0, 4000)) - 2000, $urandom, $urandom);
			default: return make_cmd(sapr_pkg::ACT_PULSE, 1'($urandom_range(0, 1)),
				$urandom, $urandom, $urandom_range(0, 65535));
		endcase
	endfunction

	// Offer one request, hold it until the block takes it, then record what
	// it must produce. The sender works in bursts; valid drops only between
	// bursts, so it is never lowered and raised within one edge.
	task automatic send_cmd(input sapr_pkg::in_item_t cmd);
		sapr_pkg::out_item_t due;
		in_valid <= 1'b1;
		in_data <= cmd;
		@(posedge clk);
		while (in_stall !== 1'b0)
			@(posedge clk);
		due = advance_servo(cmd);
		pending_outputs.push_back(due);
		last_done = due.move_done;
		items_sent++;
		if (burst_left == 0) begin
			in_valid <= 1'b0;
			if ($urandom_range(0, 4) == 0)
				repeat ($urandom_range(10, 60)) @(posedge clk);
			else
				repeat ($urandom_range(1, 4)) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
				: $urandom_range(0, 8);
		end else begin
			burst_left--;
		end
	endtask

	// Stop sending and wait until every owed result is back, then let the
	// block settle so it is surely idle.
	task automatic wait_for_idle();
		in_valid <= 1'b0;
		while (pending_outputs.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Write all five range registers, one per edge, with the block idle.
	task automatic load_ranges(input int min_a, input int max_a, input int min_p,
		input int max_p, input int per);
		logic [sapr_pkg::CFG_IDX_W-1:0] regs [5];
		int                             vals [5];
		regs = '{sapr_pkg::CFG_MIN_ANGLE, sapr_pkg::CFG_MAX_ANGLE, sapr_pkg::CFG_MIN_PULSE,
			sapr_pkg::CFG_MAX_PULSE, sapr_pkg::CFG_PERIOD};
		vals = '{min_a, max_a, min_p, max_p, per};
		wait_for_idle();
		foreach (regs[i]) begin
			cfg_we <= 1'b1;
			cfg_index <= regs[i];
			cfg_data <= vals[i][15:0];
			@(posedge clk);
			case (regs[i])
				sapr_pkg::CFG_MIN_ANGLE: lim_min_angle = vals[i][15:0];
				sapr_pkg::CFG_MAX_ANGLE: lim_max_angle = vals[i][15:0];
				sapr_pkg::CFG_MIN_PULSE: lim_min_pulse = vals[i][15:0];
				sapr_pkg::CFG_MAX_PULSE: lim_max_pulse = vals[i][15:0];
				sapr_pkg::CFG_PERIOD:    lim_period = vals[i][15:0];
				default: ;
			endcase
		end
		cfg_we <= 1'b0;
		range_settings++;
	endtask

	// A timed move played the way firmware plays it: the move command is
	// repeated with ticks in between until it lands or 24 tries are spent. Now
	// and then a stray request lands in the middle, or the target changes and
	// the move restarts from wherever the servo is.
	task automatic issue_move_sequence();
		int goal;
		int ms;
		int steps;
		if ($urandom_range(0, 4) == 0)
			goal = int'($urandom_range(0, 65535)) - 32768;
		else
			goal = int'($urandom_range(0, 36999)) - 18500;
		case ($urandom_range(0, 19))
			0, 1: ms = 0;
			2: ms = $urandom_range(13, 65535);
			3: ms = $urandom_range(13, 40);
			default: ms = $urandom_range(1, 12);
		endcase
		last_done = 1'b0;
		for (steps = 0; steps < 24 && !last_done; steps++) begin
			send_cmd(make_cmd(sapr_pkg::ACT_MOVE, 1'($urandom_range(0, 1)), goal, ms,
				$urandom));
			if (!last_done) begin
				repeat ($urandom_range(0, 3))
					send_cmd(make_cmd(sapr_pkg::ACT_TICK, 1'($urandom_range(0, 1)),
						$urandom, $urandom, $urandom));
				case ($urandom_range(0, 19))
					0: send_cmd(stray_cmd());
					1: goal = int'($urandom_range(0, 36999)) - 18500;
					default: ;
				endcase
			end
		end
	endtask

	// Mostly timed moves, then in-span angles and pulses, then noise.
	task automatic run_mixed(input int n);
		int stop;
		stop = items_sent + n;
		while (items_sent < stop) begin
			case ($urandom_range(0, 9))
				0, 1, 2, 3, 4: issue_move_sequence();
				5, 6, 7: send_cmd(sweep_cmd());
				default: send_cmd(stray_cmd());
			endcase
		end
	endtask

	// Hand-picked requests under the reset ranges (0 to 180 degrees, 500 to
	// 2500 counts): clamping at both ends, the direction bit, rounding,
	// every command, the spare codes and a short timed move.
	task automatic test_directed_commands();
		send_cmd(make_cmd(sapr_pkg::ACT_ABS, 1'b1, 0, 0, 0));
		send_cmd(make_cmd(sapr_pkg::ACT_ABS, 1'b1, 18000, 0, 0));
		send_cmd(make_cmd(sapr_pkg::ACT_ABS, 1'b1, 32767, 0, 0));
		send_cmd(make_cmd(sapr_pkg::ACT_ABS, 1'b0, -32768, 0, 0));
		send_cmd(make_cmd(sapr_pkg::ACT_ABS, 1'b1, -32768, 0, 0));
		send_cmd(make_cmd(sapr_pkg::ACT_ABS, 1'b0, 4500, 0, 0));
		send_cmd(make_cmd(sapr_pkg::ACT_ABS, 1'b1, 9001, 0, 0));
		send_cmd(make_cmd(sapr_pkg::ACT_REL, 1'b1, 1000, 0, 0));
		send_cmd(make_cmd(sapr_pkg::ACT_REL, 1'b0, 3000, 0, 0));
		send_cmd(make_cmd(sapr_pkg::ACT_REL, 1'b1, 32767, 0, 0));
		send_cmd(make_cmd(sapr_pkg::ACT_PULSE, 1'b0, 0, 0, 0));
		send_cmd(make_cmd(sapr_pkg::ACT_PULSE, 1'b0, 0, 0, 65535));
		send_cmd(make_cmd(sapr_pkg::ACT_PULSE, 1'b1, 0, 0, 1234));
		send_cmd(make_cmd(sapr_pkg::ACT_TICK, 1'b1, -1, 65535, 65535));
		send_cmd(make_cmd(ACT_SPARE5, 1'b1, -1, 65535, 65535));
		send_cmd(make_cmd(ACT_SPARE6, 1'b0, 0, 0, 0));
		send_cmd(make_cmd(ACT_SPARE7, 1'b1, -1, 65535, 65535));
		// A zero duration moves at once.
		send_cmd(make_cmd(sapr_pkg::ACT_MOVE, 1'b0, 9000, 0, 0));
		// A three tick move back to zero, polled after each tick.
		send_cmd(make_cmd(sapr_pkg::ACT_MOVE, 1'b1, 0, 3, 0));
		repeat (3) begin
			send_cmd(make_cmd(sapr_pkg::ACT_TICK, 1'b0, 0, 0, 0));
			send_cmd(make_cmd(sapr_pkg::ACT_MOVE, 1'b1, 0, 3, 0));
		end
	endtask

	task automatic test_default_ranges();
		run_mixed(300);
	endtask

	// Wide settings: the full pulse and period range, angles -18000 to 18000.
	task automatic test_full_span();
		load_ranges(-18000, 18000, 0, 65535, 65535);
		run_mixed(250);
	endtask

	// The mapping falls as the angle rises; the limit pins the pulse to max_pulse.
	task automatic test_inverted_pulse_range();
		load_ranges(-9000, 9000, 3000, 1000, 2000);
		run_mixed(200);
	endtask

	// Empty and inverted angle ranges: every angle lands on min_angle or
	// max_angle and the pulse is min_pulse before limiting.
	task automatic test_flat_angle_range();
		load_ranges(4500, 4500, 800, 2200, 19999);
		run_mixed(70);
		load_ranges(9000, -9000, 1200, 1800, 19999);
		run_mixed(70);
		load_ranges(18000, 18000, 65535, 65535, 65535);
		run_mixed(40);
	endtask

	// A period of zero pins the pulse to zero; a small one caps the range.
	task automatic test_period_limit();
		load_ranges(0, 18000, 500, 2500, 0);
		run_mixed(100);
		load_ranges(-18000, 0, 1000, 40000, 1500);
		run_mixed(130);
	endtask

	task automatic test_random_ranges();
		int min_a;
		int max_a;
		repeat (4) begin
			min_a = int'($urandom_range(0, 34999)) - 18000;
			max_a = min_a + 1 + int'($urandom_range(0, 17999 - min_a));
			load_ranges(min_a, max_a, $urandom_range(0, 65535), $urandom_range(0, 65535),
				($urandom_range(0, 1) == 1) ? 65535 : $urandom_range(0, 65535));
			run_mixed(110);
		end
	endtask

	// Result checker and receiver. A result counts at an edge where valid is
	// high and stall is low; both are read as they stood before the edge. The
	// stall follows its own rhythm of short and long runs, with short and long
	// free stretches in between.
	always @(posedge clk) begin
		if (arst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
			results_seen++;
			if (pending_outputs.size() == 0) begin
				fail_count++;
				if (fail_count <= REPORT_LIMIT)
					$display("Unexpected result: pulse %0d angle %0d done %0b",
						out_data.pulse_width, out_data.current_angle, out_data.move_done);
			end else begin
				want = pending_outputs.pop_front();
				if (out_data.pulse_width !== want.pulse_width
					|| out_data.current_angle !== want.current_angle
					|| out_data.move_done !== want.move_done) begin
					fail_count++;
					if (fail_count <= REPORT_LIMIT) begin
						$display("Mismatch at result %0d: expected pulse %0d angle %0d done %0b",
							results_seen, want.pulse_width, want.current_angle,
							want.move_done);
						$display("    got pulse %0d angle %0d done %0b",
							out_data.pulse_width, out_data.current_angle,
							out_data.move_done);
					end
				end
				if (want.move_done)
					moves_landed++;
			end
		end
		if (stall_run == 0) begin
			stall_hold = !stall_hold;
			if (stall_hold)
				stall_run = ($urandom_range(0, 3) == 0) ? $urandom_range(8, 40)
					: $urandom_range(1, 4);
			else
				stall_run = ($urandom_range(0, 5) == 0) ? $urandom_range(100, 300)
					: $urandom_range(1, 25);
		end else begin
			stall_run--;
		end
		out_stall <= stall_hold;
	end

	// Watchdog: a hung handshake ends the run as a failure.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Run stopped at the cycle limit with %0d results outstanding",
				pending_outputs.size());
			$display("Test completed with failures");
			$finish;
		end
	end

	initial begin
		// Our copy starts from the reset defaults.
		lim_min_angle = sapr_pkg::RST_MIN_ANGLE;
		lim_max_angle = sapr_pkg::RST_MAX_ANGLE;
		lim_min_pulse = sapr_pkg::RST_MIN_PULSE;
		lim_max_pulse = sapr_pkg::RST_MAX_PULSE;
		lim_period = sapr_pkg::RST_PERIOD;
		angle_held = '0;
		pulse_held = sapr_pkg::RST_MIN_PULSE;
		target_held = '0;
		move_ms = '0;
		end_tick = '0;
		span_held = '0;
		tick_count = '0;

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		test_directed_commands();
		test_default_ranges();
		test_full_span();
		test_inverted_pulse_range();
		test_flat_angle_range();
		test_period_limit();
		test_random_ranges();

		// Let everything drain, then give the block time to show any result
		// it should not produce.
		wait_for_idle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (pending_outputs.size() != 0) begin
			fail_count += pending_outputs.size();
			$display("%0d expected results never arrived", pending_outputs.size());
		end

		$display("Checked %0d results from %0d requests over %0d range settings.",
			results_seen, items_sent, range_settings);
		$display("Timed moves that reached their target: %0d; failures: %0d.",
			moves_landed, fail_count);
		if (fail_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

// File: servo_angle_to_pulse_ramp_top.f
+incdir+design
design/sapr_pkg.sv
design/sapr_div.sv
design/sapr_ctrl.sv
design/sapr_dp.sv
design/servo_angle_to_pulse_ramp_top.sv
design/sapr_checker.sv
dv/tb_servo_angle_to_pulse_ramp_top.sv
